// File: rtl/crrt_pkg.sv
// Shared types, codes and decoding functions of the cookie range remap table.
package crrt_pkg;

    // Item opcodes; the last code performs no operation.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOKIE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP = 1'b1;

    localparam logic [31:0] COOKIE_RESET   = 32'h0000_0000;
    localparam logic [31:0] MAX_DISP_RESET = 32'h0000_0200;

    // Input and result transactions.
    typedef struct packed {
        opcode_t     opcode;
        logic [63:0] operand;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] translated;
    } out_item_t;

    // One stored table entry.
    typedef struct packed {
        logic [31:0] low_word;
        logic [63:0] decoded_base;
    } entry_t;

    // Scan engine response, valid for one cycle when done is high.
    typedef struct packed {
        logic        done;
        logic        hit;
        logic [31:0] low_word;
        logic [31:0] disp;
    } scan_rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_DISPATCH  = 3'd1,
        S_SCAN      = 3'd2,
        S_TRANSLATE = 3'd3,
        S_FINISH    = 3'd4
    } state_t;

    // Rotate left of a 64-bit word; a rotate right by 64 - n is the same thing.
    function automatic logic [63:0] rol64(input logic [63:0] v, input logic [5:0] n);
        logic [127:0] wide;
        wide = {v, v} << n;
        return wide[127:64];
    endfunction

    // Rotate left of a 32-bit word.
    function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] wide;
        wide = {v, v} << n;
        return wide[63:32];
    endfunction

    // Decode a 64-bit encoded pointer under the cookie.
    function automatic logic [63:0] unmask64(input logic [63:0] enc, input logic [31:0] key);
        return rol64(enc, key[5:0]) ^ {32'h0, key};
    endfunction

    // Decode a 32-bit encoded word under the cookie.
    function automatic logic [31:0] unmask32(input logic [31:0] enc, input logic [31:0] key);
        return rol32(enc, key[4:0]) ^ key;
    endfunction

endpackage

// File: rtl/crrt_scan.sv
// Entry memory and the sequential first-match scan engine.
module crrt_scan #(
    parameter int TABLE_DEPTH = 1024,
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  crrt_pkg::entry_t    wr_entry,
    input  logic                start,
    input  logic [CNT_W-1:0]    count,
    input  logic [63:0]         value,
    input  logic [31:0]         max_disp,
    output crrt_pkg::scan_rsp_t rsp
);
    import crrt_pkg::*;

    entry_t mem [TABLE_DEPTH];

    logic             busy_reg, busy_next;
    logic             pending_reg, pending_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    entry_t           rd_data_reg;

    logic             rd_en;
    logic [64:0]      diff;
    logic             in_range;
    logic             hit;
    logic             exhausted;

    // A read is issued every cycle while entries remain to be fetched.
    assign rd_en = busy_reg && (issue_reg < count);

    // Range check of the entry that came out of the memory last cycle.
    assign diff      = {1'b0, value} - {1'b0, rd_data_reg.decoded_base};
    assign in_range  = !diff[64] && (diff[63:32] == 32'h0) && (diff[31:0] <= max_disp);
    assign hit       = busy_reg && pending_reg && in_range;
    assign exhausted = busy_reg && !pending_reg && !rd_en;

    assign rsp.done     = hit || exhausted;
    assign rsp.hit      = hit;
    assign rsp.low_word = rd_data_reg.low_word;
    assign rsp.disp     = diff[31:0];

    // Scan control: stop at the first hit or when the table is exhausted.
    always_comb begin
        busy_next    = busy_reg;
        pending_next = rd_en;
        issue_next   = issue_reg;
        if (start) begin
            busy_next    = 1'b1;
            pending_next = 1'b0;
            issue_next   = '0;
        end else if (busy_reg) begin
            if (rsp.done) begin
                busy_next = 1'b0;
            end
            if (rd_en) begin
                issue_next = issue_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pending_reg <= 1'b0;
            issue_reg   <= '0;
        end else begin
            busy_reg    <= busy_next;
            pending_reg <= pending_next;
            issue_reg   <= issue_next;
        end
    end

    // Single-port style memory with a registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[issue_reg[ADDR_W-1:0]];
        end
    end

endmodule

// File: rtl/cookie_range_remap_table.sv
// Top level of the cookie range remap table: control, configuration and result register.
//
// The block keeps a table of up to TABLE_DEPTH decoded pointers in an on-chip
// memory and handles one transaction at a time. A clear or a load passes
// through the dispatch and finish states before its result reaches the output
// register. A query reads the loaded entries one per cycle through the memory's
// single read port, and a match ends the scan early. A new input transaction is
// taken as soon as the previous one has moved into the output register, even
// while that result still waits for m_ready. The memory is not cleared after
// reset; the entry count alone tells which entries hold data.
module cookie_range_remap_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  crrt_pkg::in_item_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output crrt_pkg::out_item_t    m_data,
    input  logic                   cfg_we,
    input  logic [crrt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_wdata
);
    import crrt_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    state_t           state_reg, state_next;
    opcode_t          op_reg;
    logic [63:0]      arg_reg;
    logic [31:0]      cookie_reg, cookie_next;
    logic [31:0]      max_disp_reg, max_disp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    out_item_t        res_reg, res_next;
    logic [31:0]      low_reg, low_next;
    logic [31:0]      disp_reg, disp_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg;

    logic             arg_zero;
    logic             full;
    logic             out_free;
    logic             scan_start;
    logic             mem_we;
    logic             out_load;
    entry_t           wr_entry;
    scan_rsp_t        scan_rsp;
    logic [32:0]      sum;

    assign arg_zero = (arg_reg == 64'h0);
    assign full     = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    assign wr_entry.low_word     = arg_reg[31:0];
    assign wr_entry.decoded_base = unmask64(arg_reg, cookie_reg);

    assign sum = {1'b0, unmask32(low_reg, cookie_reg)} + {1'b0, disp_reg};

    crrt_scan #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_we),
        .wr_addr  (count_reg[ADDR_W-1:0]),
        .wr_entry (wr_entry),
        .start    (scan_start),
        .count    (count_reg),
        .value    (arg_reg),
        .max_disp (max_disp_reg),
        .rsp      (scan_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = scan_start ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                if (scan_rsp.done) begin
                    state_next = scan_rsp.hit ? S_TRANSLATE : S_FINISH;
                end
            end
            S_TRANSLATE: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_ready    = 1'b0;
        scan_start = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_DISPATCH: begin
                scan_start = (op_reg == OP_QUERY) && !arg_zero && (count_reg != '0);
                mem_we     = (op_reg == OP_LOAD) && !arg_zero && !full;
            end
            S_FINISH: begin
                out_load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Table count, pending result and match capture.
    always_comb begin
        count_next = count_reg;
        res_next   = res_reg;
        low_next   = low_reg;
        disp_next  = disp_reg;
        if (state_reg == S_DISPATCH) begin
            res_next.status     = ST_OK;
            res_next.translated = 64'h0;
            case (op_reg)
                OP_CLEAR: begin
                    count_next = '0;
                end
                OP_LOAD: begin
                    if (!arg_zero && full) begin
                        res_next.status = ST_FULL;
                    end
                    if (mem_we) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_QUERY: begin
                    if (!scan_start) begin
                        res_next.status = ST_NO_MATCH;
                    end
                end
                default: begin
                    res_next.status = ST_OK;
                end
            endcase
        end
        if ((state_reg == S_SCAN) && scan_rsp.done) begin
            if (scan_rsp.hit) begin
                low_next  = scan_rsp.low_word;
                disp_next = scan_rsp.disp;
            end else begin
                res_next.status     = ST_NO_MATCH;
                res_next.translated = 64'h0;
            end
        end
        if (state_reg == S_TRANSLATE) begin
            res_next.status     = ST_OK;
            res_next.translated = {31'h0, sum};
        end
    end

    // Configuration writes.
    always_comb begin
        cookie_next   = cookie_reg;
        max_disp_next = max_disp_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_COOKIE:   cookie_next   = cfg_wdata;
                CFG_MAX_DISP: max_disp_next = cfg_wdata;
                default:      cookie_next   = cookie_reg;
            endcase
        end
    end

    // Output register: loaded when a result is ready and the slot is free.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cookie_reg   <= COOKIE_RESET;
            max_disp_reg <= MAX_DISP_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cookie_reg   <= cookie_next;
            max_disp_reg <= max_disp_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_data.opcode;
            arg_reg <= s_data.operand;
        end
        res_reg  <= res_next;
        low_reg  <= low_next;
        disp_reg <= disp_next;
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The entry count never passes the table depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A successful load grows the table by exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("load did not advance the entry count");

    // The scan engine reports completion only while the controller waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_rsp.done |-> (state_reg == S_SCAN))
        else $error("scan completion outside of scan state");

    // A result moves to the output only after the controller has finished an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (state_reg == S_FINISH))
        else $error("output loaded outside of finish state");

endmodule
